### hdl/gpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpa_pkg
// Shared types and codes for the greedy track/detection pair assignment block.
// ----------------------------------------------------------------------------
package gpa_pkg;

  // op codes of an input word
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_PAIR  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_ASSIGN     = 3'd0;
  localparam logic [2:0] KIND_FREE_DET   = 3'd1;
  localparam logic [2:0] KIND_FREE_TRACK = 3'd2;
  localparam logic [2:0] KIND_DONE       = 3'd3;
  localparam logic [2:0] KIND_REJECT     = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  track_count;
    logic [5:0]  detection_count;
    logic [4:0]  pair_track;
    logic [4:0]  pair_detection;
    logic [15:0] pair_score;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [4:0]  out_track;
    logic [4:0]  out_detection;
    logic [15:0] out_score;
    logic        last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic frame_load;
    logic pair_check;
    logic scan_start;
    logic phase_switch;
    logic scan_det;
    logic scan_trk;
    logic flush;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic det_left;
    logic trk_left;
  } stat_t;

endpackage

`default_nettype wire

### hdl/greedy_pair_assignment.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_pair_assignment
// Greedy one-to-one matching of score-sorted track/detection pairs.
//
//   channel  ports               handshake
//   -------  ------------------  ------------------------------------
//   input    cmd  (cmd_t)        word taken when start && !busy
//   output   result (result_t)   word valid for the one cycle strobe is high
//
// Begin and pair words leave busy low: a new word can follow every cycle
// while busy is low. An assigned or rejected pair shows its result the
// cycle after it is taken; a pair with a used track or detection gives none.
// An end word holds busy for the scan: one map bit per cycle, one pass per map.
// Synchronous reset clears the maps and counts; no clearing pass is needed.
// The receiver cannot stall; results are never held back.
// ----------------------------------------------------------------------------
module greedy_pair_assignment #(
  parameter int MAX_TRACKS     = 32,
  parameter int MAX_DETECTIONS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire gpa_pkg::cmd_t    cmd,
  output logic                  busy,
  output logic                  strobe,
  output gpa_pkg::result_t      result
);
  import gpa_pkg::*;

  ctl_t  ctl;
  stat_t stat;

  gpa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (cmd.op),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  gpa_datapath #(
    .MAX_TRACKS     (MAX_TRACKS),
    .MAX_DETECTIONS (MAX_DETECTIONS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .ctl    (ctl),
    .stat   (stat),
    .strobe (strobe),
    .result (result)
  );

endmodule

`default_nettype wire

### hdl/gpa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpa_ctrl
// Sequencer: decodes accepted words and walks the end-of-frame scan phases.
// ----------------------------------------------------------------------------
module gpa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    op,
  input  wire gpa_pkg::stat_t stat,
  output gpa_pkg::ctl_t      ctl,
  output logic               busy
);
  import gpa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DET,
    S_TRK
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start && !busy) begin
          case (op)
            OP_BEGIN: ctl.frame_load = 1'b1;
            OP_PAIR:  ctl.pair_check = 1'b1;
            OP_END: begin
              ctl.scan_start = 1'b1;
              state_next     = S_DET;
            end
            default: ;
          endcase
        end
      end
      S_DET: begin
        if (stat.det_left) begin
          ctl.scan_det = 1'b1;
        end else begin
          ctl.phase_switch = 1'b1;
          state_next       = S_TRK;
        end
      end
      S_TRK: begin
        if (stat.trk_left) begin
          ctl.scan_trk = 1'b1;
        end else begin
          ctl.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
    end
  end

  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy == (state != S_IDLE)) else $error("busy out of step with state");

  a_ctl_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ctl)) else $error("more than one datapath command");

  a_flush_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.flush |=> !busy) else $error("still busy after flush");

endmodule

`default_nettype wire

### hdl/gpa_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gpa_datapath
// Used maps, frame counts, scan index, one-deep hold word and result register.
// ----------------------------------------------------------------------------
module gpa_datapath #(
  parameter int MAX_TRACKS     = 32,
  parameter int MAX_DETECTIONS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire gpa_pkg::cmd_t   cmd,
  input  wire gpa_pkg::ctl_t   ctl,
  output gpa_pkg::stat_t       stat,
  output logic                 strobe,
  output gpa_pkg::result_t     result
);
  import gpa_pkg::*;

  localparam int TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int DW = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam logic [5:0] TMAX = 6'(MAX_TRACKS);
  localparam logic [5:0] DMAX = 6'(MAX_DETECTIONS);

  logic [MAX_TRACKS-1:0]     track_taken;
  logic [MAX_DETECTIONS-1:0] detection_taken;
  logic [5:0]                frame_tracks;
  logic [5:0]                frame_detections;
  logic [5:0]                idx;
  logic                      pend_vld;
  result_t                   pend;

  logic pair_in_range;
  logic pair_free;
  logic det_free;
  logic trk_free;

  // indices are only used once they are known to be below the frame count
  assign pair_in_range = ({1'b0, cmd.pair_track} < frame_tracks) &&
                         ({1'b0, cmd.pair_detection} < frame_detections);
  assign pair_free = !track_taken[cmd.pair_track[TW-1:0]] &&
                     !detection_taken[cmd.pair_detection[DW-1:0]];
  assign det_free  = !detection_taken[idx[DW-1:0]];
  assign trk_free  = !track_taken[idx[TW-1:0]];

  assign stat.det_left = idx < frame_detections;
  assign stat.trk_left = idx < frame_tracks;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      track_taken      <= '0;
      detection_taken  <= '0;
      frame_tracks     <= '0;
      frame_detections <= '0;
      idx              <= '0;
      pend_vld         <= 1'b0;
      strobe           <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (ctl.frame_load) begin
        frame_tracks     <= (cmd.track_count > TMAX) ? TMAX : cmd.track_count;
        frame_detections <= (cmd.detection_count > DMAX) ? DMAX : cmd.detection_count;
        track_taken      <= '0;
        detection_taken  <= '0;
      end
      if (ctl.pair_check) begin
        if (!pair_in_range) begin
          strobe <= 1'b1;
        end else if (pair_free) begin
          strobe                                      <= 1'b1;
          track_taken[cmd.pair_track[TW-1:0]]         <= 1'b1;
          detection_taken[cmd.pair_detection[DW-1:0]] <= 1'b1;
        end
      end
      if (ctl.scan_start) begin
        idx      <= '0;
        pend_vld <= 1'b0;
      end
      if (ctl.phase_switch) begin
        idx <= '0;
      end
      if (ctl.scan_det) begin
        idx <= idx + 6'd1;
        if (det_free) begin
          strobe   <= pend_vld;
          pend_vld <= 1'b1;
        end
      end
      if (ctl.scan_trk) begin
        idx <= idx + 6'd1;
        if (trk_free) begin
          strobe   <= pend_vld;
          pend_vld <= 1'b1;
        end
      end
      if (ctl.flush) begin
        strobe   <= 1'b1;
        pend_vld <= 1'b0;
      end
    end
  end

  // payload: a free entry is held back in the hold word so the final word can carry last
  always_ff @(posedge clk) begin
    if (ctl.pair_check) begin
      if (!pair_in_range) begin
        result <= '{kind: KIND_REJECT, out_track: cmd.pair_track,
                    out_detection: cmd.pair_detection, out_score: 16'd0, last: 1'b1};
      end else if (pair_free) begin
        result <= '{kind: KIND_ASSIGN, out_track: cmd.pair_track,
                    out_detection: cmd.pair_detection, out_score: cmd.pair_score,
                    last: 1'b1};
      end
    end
    if (ctl.scan_det && det_free) begin
      result <= pend;
      pend   <= '{kind: KIND_FREE_DET, out_track: 5'd0, out_detection: idx[4:0],
                  out_score: 16'd0, last: 1'b0};
    end
    if (ctl.scan_trk && trk_free) begin
      result <= pend;
      pend   <= '{kind: KIND_FREE_TRACK, out_track: idx[4:0], out_detection: 5'd0,
                  out_score: 16'd0, last: 1'b0};
    end
    if (ctl.flush) begin
      if (pend_vld) begin
        result <= '{kind: pend.kind, out_track: pend.out_track,
                    out_detection: pend.out_detection, out_score: pend.out_score,
                    last: 1'b1};
      end else begin
        result <= '{kind: KIND_DONE, out_track: 5'd0, out_detection: 5'd0,
                    out_score: 16'd0, last: 1'b1};
      end
    end
  end

  a_assign_marked: assert property (@(posedge clk) disable iff (rst)
    strobe && result.kind == KIND_ASSIGN |->
      track_taken[result.out_track[TW-1:0]] &&
      detection_taken[result.out_detection[DW-1:0]])
    else $error("assignment word without both map bits set");

  a_pend_kind: assert property (@(posedge clk) disable iff (rst)
    pend_vld |-> (pend.kind == KIND_FREE_DET || pend.kind == KIND_FREE_TRACK))
    else $error("hold word has a bad kind");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    ctl.scan_det |-> idx < frame_detections && idx <= 6'(MAX_DETECTIONS))
    else $error("detection scan past frame count");

endmodule

`default_nettype wire
